// ----- rtl/core/binary_to_decimal_ascii_assert.svh -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// shared macros for concurrent checks on the converter ports
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define B2DA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B2DA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// b2da_pkg
// shared types and constants of the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int DIGITS    = 10;
    localparam int DCNT_W    = 4;
    localparam int CHAR_W    = 8;
    localparam int IN_W      = 32;
    localparam int SIZE_W    = 8;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = 1;
    localparam int Q_CW      = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_SMALL = 1'b1;

    typedef logic [DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        t_bcd              digit;
        logic [DCNT_W-1:0] count;
        logic              err;
    } t_conv;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/core/b2da_front.sv -----
// ----------------------------------------------------------------------------
// b2da_front
// accepts a value, converts it bit-serially to bcd and classifies the fit
// ----------------------------------------------------------------------------
module b2da_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [b2da_pkg::IN_W-1:0]          i_value,
    input  logic [b2da_pkg::SIZE_W-1:0]        i_buffer_size,
    input  b2da_pkg::t_q_stat                  i_q_stat,
    output logic                               o_push,
    output b2da_pkg::t_conv                    o_entry
);

    localparam int W  = (VALUE_BITS > b2da_pkg::IN_W) ? b2da_pkg::IN_W : VALUE_BITS;
    localparam int BW = $clog2(W);

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_COUNT, S_PUSH} t_state;

    t_state                              r_state, n_state;
    logic [W-1:0]                        r_val, n_val;
    logic [b2da_pkg::SIZE_W-1:0]         r_size, n_size;
    b2da_pkg::t_bcd                      r_bcd, n_bcd;
    logic [BW-1:0]                       r_bit, n_bit;
    logic [b2da_pkg::DCNT_W-1:0]         r_cnt, n_cnt;
    logic                                r_err, n_err;

    b2da_pkg::t_bcd                      adj;
    logic [4*b2da_pkg::DIGITS-1:0]       adj_flat;
    logic [b2da_pkg::DCNT_W-1:0]         nd;

    always_comb begin
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        adj_flat = adj;
    end

    always_comb begin
        nd = b2da_pkg::DCNT_W'(1);
        for (int i = 1; i < b2da_pkg::DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                nd = b2da_pkg::DCNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_size  = r_size;
        n_bcd   = r_bcd;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val   = i_value[W-1:0];
                    n_size  = i_buffer_size;
                    n_bcd   = '0;
                    n_bit   = BW'(W - 1);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_bcd = {adj_flat[4*b2da_pkg::DIGITS-2:0], r_val[W-1]};
                n_val = {r_val[W-2:0], 1'b0};
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_cnt   = nd;
                n_err   = (r_size <= {{(b2da_pkg::SIZE_W-b2da_pkg::DCNT_W){1'b0}}, nd});
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_val  <= n_val;
        r_size <= n_size;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_err  <= n_err;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_push        = (r_state == S_PUSH) && !i_q_stat.full;
    assign o_entry.digit = r_bcd;
    assign o_entry.count = r_cnt;
    assign o_entry.err   = r_err;

endmodule

// ----- rtl/core/b2da_queue.sv -----
// ----------------------------------------------------------------------------
// b2da_queue
// two-entry queue of converted items between front and back
// ----------------------------------------------------------------------------
module b2da_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b2da_pkg::t_conv   i_entry,
    input  logic              i_pop,
    output b2da_pkg::t_conv   o_entry,
    output b2da_pkg::t_q_stat o_stat
);

    b2da_pkg::t_conv                 mem [b2da_pkg::Q_DEPTH];
    logic [b2da_pkg::Q_AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [b2da_pkg::Q_AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [b2da_pkg::Q_CW-1:0]       r_count, n_count;
    b2da_pkg::t_conv                 r_rd_data;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == b2da_pkg::Q_AW'(b2da_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + b2da_pkg::Q_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == b2da_pkg::Q_AW'(b2da_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + b2da_pkg::Q_AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + b2da_pkg::Q_CW'(1);
            2'b01:   n_count = r_count - b2da_pkg::Q_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_entry;
        end
        if (i_pop) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    assign o_entry     = r_rd_data;
    assign o_stat.full  = (r_count == b2da_pkg::Q_CW'(b2da_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- rtl/core/b2da_back.sv -----
// ----------------------------------------------------------------------------
// b2da_back
// takes converted items from the queue and emits the character stream
// ----------------------------------------------------------------------------
module b2da_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  b2da_pkg::t_q_stat                i_q_stat,
    input  b2da_pkg::t_conv                  i_entry,
    output logic                             o_pop,
    output logic                             o_strobe,
    output logic [b2da_pkg::CHAR_W-1:0]      o_character,
    output logic                             o_status,
    output logic                             o_last
);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIGIT, S_TERM} t_state;

    t_state                          r_state, n_state;
    logic [b2da_pkg::DCNT_W-1:0]     r_idx, n_idx;
    logic                            r_strobe, n_strobe;
    logic [b2da_pkg::CHAR_W-1:0]     r_char, n_char;
    logic                            r_status, n_status;
    logic                            r_last, n_last;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_status = r_status;
        n_last   = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_entry.err) begin
                    n_strobe = 1'b1;
                    n_char   = b2da_pkg::ASCII_NUL;
                    n_status = b2da_pkg::ST_SMALL;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = i_entry.count - b2da_pkg::DCNT_W'(1);
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                n_strobe = 1'b1;
                n_char   = b2da_pkg::ASCII_ZERO + {4'd0, i_entry.digit[r_idx]};
                n_status = b2da_pkg::ST_OK;
                n_last   = 1'b0;
                n_idx    = r_idx - b2da_pkg::DCNT_W'(1);
                if (r_idx == '0) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                n_strobe = 1'b1;
                n_char   = b2da_pkg::ASCII_NUL;
                n_status = b2da_pkg::ST_OK;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_idx    <= n_idx;
        r_char   <= n_char;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// ----- rtl/core/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// unsigned binary to decimal ascii string converter, top level
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_value and i_buffer_size and raise start; the item is taken on a
//   clock edge where start is high and busy is low. busy stays high while the
//   front converts the low VALUE_BITS (at most 32) bits of the value with a
//   bit-serial shift-and-add-3 loop, one value bit per cycle, and while it
//   waits for room in the two-entry queue that carries converted items to the
//   back, which emits one character per cycle on o_character with o_strobe
//   high for one cycle: the digits most significant first, then a NUL with
//   o_last set. If the string and its terminator do not fit i_buffer_size, a
//   single transfer with character 0, o_status 1 and o_last 1 is emitted
//   instead, from the load state of the back; digits come from its digit
//   state and the NUL from its terminator state. The front takes a new value
//   once the previous one is in the queue, so conversion overlaps the
//   emission of earlier strings; the serial loop sets the sustained rate.
//   Synchronous active-low reset empties the queue and idles both parts.
//   The receiver cannot stall: each transfer is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [b2da_pkg::IN_W-1:0]     i_value,
    input  logic [b2da_pkg::SIZE_W-1:0]   i_buffer_size,
    output logic                          o_strobe,
    output logic [b2da_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_status,
    output logic                          o_last
);

    b2da_pkg::t_q_stat q_stat;
    b2da_pkg::t_conv   push_entry;
    b2da_pkg::t_conv   pop_entry;
    logic              push;
    logic              pop;

    b2da_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_value       (i_value),
        .i_buffer_size (i_buffer_size),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    b2da_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (q_stat)
    );

    b2da_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ----- rtl/core/b2da_checker.sv -----
// ----------------------------------------------------------------------------
// b2da_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_assert.svh"

module b2da_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [b2da_pkg::IN_W-1:0]     i_value,
    input logic [b2da_pkg::SIZE_W-1:0]   i_buffer_size,
    input logic                          o_strobe,
    input logic [b2da_pkg::CHAR_W-1:0]   o_character,
    input logic                          o_status,
    input logic                          o_last
);

    logic unused_in;
    assign unused_in = ^{i_value, i_buffer_size};

    `B2DA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy low after accept")

    `B2DA_ASSERT_IMP(a_err_form, i_clk, i_rst_n, o_strobe && o_status, o_last && (o_character == b2da_pkg::ASCII_NUL), "malformed error transfer")

    `B2DA_ASSERT_IMP(a_digit_form, i_clk, i_rst_n, o_strobe && !o_last, !o_status && (o_character >= 8'h30) && (o_character <= 8'h39), "non-digit character")

    `B2DA_ASSERT_NXT(a_string_cont, i_clk, i_rst_n, o_strobe && !o_last, o_strobe && !o_status, "string broken after digit")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

// ----- sim/binary_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// self-checking bench for the binary to decimal ascii converter: directed
// corner values and capacities, groups of random items each followed by a
// drain, then random values of every digit length with random start gaps;
// each character transfer is checked against a queue of predicted characters
// built when the item is accepted
module binary_to_decimal_ascii_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 48;

    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] character;
        logic                        status;
        logic                        last;
    } t_char_rec;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [b2da_pkg::IN_W-1:0]   i_value;
    logic [b2da_pkg::SIZE_W-1:0] i_buffer_size;
    logic                        o_strobe;
    logic [b2da_pkg::CHAR_W-1:0] o_character;
    logic                        o_status;
    logic                        o_last;

    t_char_rec expected_chars[$];
    t_char_rec want_char;
    int        error_count;
    int        idle_cycles;
    bit        burst_mode;

    binary_to_decimal_ascii i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_buffer_size (i_buffer_size),
        .o_strobe      (o_strobe),
        .o_character   (o_character),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic int count_digits(logic [b2da_pkg::IN_W-1:0] value);
        logic [b2da_pkg::IN_W-1:0] rest;
        int                        n;
        rest = value;
        n = 0;
        do begin
            n++;
            rest = rest / 10;
        end while (rest != 0);
        return n;
    endfunction

    function automatic void predict_decimal_string(logic [b2da_pkg::IN_W-1:0] value,
                                                   logic [b2da_pkg::SIZE_W-1:0] size);
        logic [3:0]                digits [b2da_pkg::DIGITS];
        logic [b2da_pkg::IN_W-1:0] rest;
        int                        n;
        t_char_rec                 rec;
        rest = value;
        n = 0;
        do begin
            digits[n] = 4'(rest % 10);
            n++;
            rest = rest / 10;
        end while (rest != 0 && n < b2da_pkg::DIGITS);
        if (int'(size) < n + 1) begin
            rec = '{character: b2da_pkg::ASCII_NUL, status: b2da_pkg::ST_SMALL,
                    last: 1'b1};
            expected_chars.push_back(rec);
        end else begin
            for (int k = n - 1; k >= 0; k--) begin
                rec = '{character: b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits[k]),
                        status: b2da_pkg::ST_OK, last: 1'b0};
                expected_chars.push_back(rec);
            end
            rec = '{character: b2da_pkg::ASCII_NUL, status: b2da_pkg::ST_OK, last: 1'b1};
            expected_chars.push_back(rec);
        end
    endfunction

    function automatic logic [b2da_pkg::IN_W-1:0] value_of_length(int len);
        longint lo;
        longint hi;
        lo = 1;
        for (int k = 1; k < len; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1) lo = 0;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(hi[31:0], lo[31:0]);
    endfunction

    function automatic logic [b2da_pkg::SIZE_W-1:0] capacity_for(int n);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return b2da_pkg::SIZE_W'(n + 1 + $urandom_range(0, 3));
            6:                return b2da_pkg::SIZE_W'(n + 1);
            7:                return b2da_pkg::SIZE_W'(n);
            8:                return b2da_pkg::SIZE_W'($urandom_range(0, n));
            default:          return b2da_pkg::SIZE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int next_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_conversion(logic [b2da_pkg::IN_W-1:0] value,
                                   logic [b2da_pkg::SIZE_W-1:0] size);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_value       = value;
        i_buffer_size = size;
        start         = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_decimal_string(value, size);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        start = 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_corner_values();
        send_conversion(32'd0, 8'd0);
        send_conversion(32'd0, 8'd1);
        send_conversion(32'd0, 8'd2);
        send_conversion(32'd9, 8'd2);
        send_conversion(32'd10, 8'd2);
        send_conversion(32'd10, 8'd3);
        send_conversion(32'd99, 8'd3);
        send_conversion(32'd100, 8'd4);
        send_conversion(32'hFFFF_FFFF, 8'd11);
        send_conversion(32'hFFFF_FFFF, 8'd10);
        send_conversion(32'hFFFF_FFFF, 8'd255);
        send_conversion(32'hFFFF_FFFF, 8'd0);
        send_conversion(32'd1000000000, 8'd11);
        send_conversion(32'd999999999, 8'd10);
        send_conversion(32'd999999999, 8'd9);
        send_conversion(32'd12345, 8'd0);
        send_conversion(32'd67890, 8'd6);
        send_conversion(32'd1, 8'd255);
        send_conversion(32'h8000_0000, 8'd11);
        send_conversion(32'h5555_5555, 8'd128);
        send_conversion(32'hAAAA_AAAA, 8'd127);
    endtask

    task automatic test_random_lengths(int items);
        logic [b2da_pkg::IN_W-1:0] value;
        for (int i = 0; i < items; i++) begin
            if (i % 20 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0) value = $urandom();
            else value = value_of_length($urandom_range(1, b2da_pkg::DIGITS));
            send_conversion(value, capacity_for(count_digits(value)));
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_drain_pauses();
        logic [b2da_pkg::IN_W-1:0] value;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 5; i++) begin
                value = value_of_length($urandom_range(1, b2da_pkg::DIGITS));
                send_conversion(value, capacity_for(count_digits(value)));
            end
            wait_for_drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer char=%0h status=%0b last=%0b",
                                          o_character, o_status, o_last));
            end else begin
                want_char = expected_chars.pop_front();
                if (o_character !== want_char.character)
                    report_mismatch($sformatf("character got %0h want %0h",
                                              o_character, want_char.character));
                if (o_status !== want_char.status)
                    report_mismatch($sformatf("status got %0b want %0b",
                                              o_status, want_char.status));
                if (o_last !== want_char.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              o_last, want_char.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_value       = '0;
        i_buffer_size = '0;
        error_count   = 0;
        idle_cycles   = 0;
        burst_mode    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_corner_values();
        test_drain_pauses();
        test_random_lengths(164);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
